/* hw/rtl/elc_pkg.sv */
`timescale 1ns / 1ps

package elc_pkg;

  localparam int ELAPSED_W = 32;
  localparam int MONTH_W   = 4;
  localparam int DAY_W     = 5;
  localparam int HOUR_W    = 5;
  localparam int MINUTE_W  = 6;
  localparam int SECOND_W  = 6;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 6;

  localparam logic [CFG_INDEX_W-1:0] REG_START_MONTH  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_START_DAY    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_START_HOUR   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_START_MINUTE = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_START_SECOND = 3'd4;

  localparam int OFFSET_W = 25;
  localparam int QS_W     = 26;
  localparam int SECS_W   = 27;
  localparam int MINS_W   = 21;
  localparam int HOURS_W  = 15;
  localparam int DAYS_W   = 10;
  localparam int YDAY_W   = 9;

  localparam int MONTHS        = 12;
  localparam int DAYS_PER_YEAR = 365;
  localparam int SECS_PER_DAY  = 86400;
  localparam int SECS_PER_HOUR = 3600;
  localparam int SECS_PER_MIN  = 60;
  localparam int HOURS_PER_DAY = 24;

  localparam logic [31:0] DIV100_MUL   = 32'h51EB851F;
  localparam logic [27:0] DIV60_MUL    = 28'd143165577;
  localparam logic [15:0] DIV24_MUL    = 16'd43691;

  localparam logic [YDAY_W-1:0] CUM_DAYS [0:MONTHS-1] = '{
    9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
    9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
  };

  typedef struct packed {
    logic                valid;
    logic [YDAY_W-1:0]   yday;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [SECOND_W-1:0] second;
  } clock_fields_t;

  function automatic logic [YDAY_W-1:0] days_before(input logic [MONTH_W-1:0] m);
    logic [YDAY_W-1:0] d;
    d = '0;
    if (m != '0) begin
      d = CUM_DAYS[m - 4'd1];
    end
    return d;
  endfunction

  function automatic logic [DAY_W:0] month_len(input logic [MONTH_W-1:0] m);
    logic [YDAY_W-1:0] d;
    d = '0;
    if (m < 4'(MONTHS)) begin
      d = CUM_DAYS[m] - days_before(m);
    end
    return d[DAY_W:0];
  endfunction

  function automatic logic [21:0] div60(input logic [SECS_W-1:0] x);
    logic [54:0] p;
    p = 55'(x) * 55'(DIV60_MUL);
    return p[54:33];
  endfunction

  function automatic logic [DAYS_W-1:0] div24(input logic [HOURS_W-1:0] x);
    logic [30:0] p;
    p = 31'(x) * 31'(DIV24_MUL);
    return p[29:20];
  endfunction

endpackage

/* hw/rtl/elc_cfg.sv */
`timescale 1ns / 1ps

module elc_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [elc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [elc_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic [elc_pkg::OFFSET_W-1:0]       offset
);

  logic [elc_pkg::MONTH_W-1:0]  month_r;
  logic [elc_pkg::DAY_W-1:0]    day_r;
  logic [elc_pkg::HOUR_W-1:0]   hour_r;
  logic [elc_pkg::MINUTE_W-1:0] minute_r;
  logic [elc_pkg::SECOND_W-1:0] second_r;
  logic [elc_pkg::OFFSET_W-1:0] offset_r;
  logic [elc_pkg::OFFSET_W-1:0] offset_nxt;
  logic [elc_pkg::MONTH_W-1:0]  month_sat;
  logic [elc_pkg::DAYS_W-1:0]   start_days;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      month_r  <= 4'd5;
      day_r    <= 5'd29;
      hour_r   <= 5'd23;
      minute_r <= 6'd59;
      second_r <= 6'd50;
    end else if (cfg_we) begin
      unique case (cfg_index)
        elc_pkg::REG_START_MONTH:  month_r  <= cfg_data[elc_pkg::MONTH_W-1:0];
        elc_pkg::REG_START_DAY:    day_r    <= cfg_data[elc_pkg::DAY_W-1:0];
        elc_pkg::REG_START_HOUR:   hour_r   <= cfg_data[elc_pkg::HOUR_W-1:0];
        elc_pkg::REG_START_MINUTE: minute_r <= cfg_data[elc_pkg::MINUTE_W-1:0];
        elc_pkg::REG_START_SECOND: second_r <= cfg_data[elc_pkg::SECOND_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    month_sat = (month_r > 4'(elc_pkg::MONTHS - 1)) ? 4'(elc_pkg::MONTHS - 1) : month_r;
    start_days = 10'(elc_pkg::days_before(month_sat)) + 10'(day_r);
    offset_nxt = 25'(start_days) * 25'(elc_pkg::SECS_PER_DAY)
               + 25'(hour_r) * 25'(elc_pkg::SECS_PER_HOUR)
               + 25'(minute_r) * 25'(elc_pkg::SECS_PER_MIN)
               + 25'(second_r);
  end

  always_ff @(posedge clk) begin
    offset_r <= offset_nxt;
  end

  assign offset = offset_r;

endmodule

/* hw/rtl/elc_split.sv */
`timescale 1ns / 1ps

module elc_split (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic [elc_pkg::ELAPSED_W-1:0]  elapsed,
  input  logic [elc_pkg::OFFSET_W-1:0]   offset,
  output elc_pkg::clock_fields_t         fields
);

  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r, s6_v_r, s7_v_r;

  logic [elc_pkg::ELAPSED_W-1:0] e_r;
  logic [elc_pkg::QS_W-1:0]      qs_r;
  logic [elc_pkg::SECS_W-1:0]    secs_r;
  logic [elc_pkg::SECS_W-1:0]    secs4_r;
  logic [elc_pkg::MINS_W-1:0]    mins4_r;
  logic [elc_pkg::MINS_W-1:0]    mins5_r;
  logic [elc_pkg::HOURS_W-1:0]   hours5_r;
  logic [elc_pkg::SECOND_W-1:0]  sec5_r;
  logic [elc_pkg::HOURS_W-1:0]   hours6_r;
  logic [elc_pkg::DAYS_W-1:0]    days6_r;
  logic [elc_pkg::MINUTE_W-1:0]  min6_r;
  logic [elc_pkg::SECOND_W-1:0]  sec6_r;
  logic [elc_pkg::YDAY_W-1:0]    yday7_r;
  logic [elc_pkg::HOUR_W-1:0]    hour7_r;
  logic [elc_pkg::MINUTE_W-1:0]  min7_r;
  logic [elc_pkg::SECOND_W-1:0]  sec7_r;

  logic [63:0]                   prod100;
  logic [21:0]                   mins_q;
  logic [21:0]                   hours_q;
  logic [elc_pkg::SECS_W-1:0]    sec_rem;
  logic [elc_pkg::MINS_W-1:0]    min_rem;
  logic [elc_pkg::HOURS_W-1:0]   hour_rem;
  logic [elc_pkg::YDAY_W-1:0]    yday_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
      s6_v_r <= 1'b0;
      s7_v_r <= 1'b0;
    end else begin
      s1_v_r <= in_valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
      s5_v_r <= s4_v_r;
      s6_v_r <= s5_v_r;
      s7_v_r <= s6_v_r;
    end
  end

  always_comb begin
    prod100  = 64'(e_r) * 64'(elc_pkg::DIV100_MUL);
    mins_q   = elc_pkg::div60(secs_r);
    hours_q  = elc_pkg::div60(27'(mins4_r));
    sec_rem  = secs4_r - ((27'(mins4_r) << 6) - (27'(mins4_r) << 2));
    min_rem  = mins5_r - ((21'(hours5_r) << 6) - (21'(hours5_r) << 2));
    hour_rem = hours6_r - ((15'(days6_r) << 4) + (15'(days6_r) << 3));
    if (days6_r >= 10'(2 * elc_pkg::DAYS_PER_YEAR)) begin
      yday_nxt = 9'(days6_r - 10'(2 * elc_pkg::DAYS_PER_YEAR));
    end else if (days6_r >= 10'(elc_pkg::DAYS_PER_YEAR)) begin
      yday_nxt = 9'(days6_r - 10'(elc_pkg::DAYS_PER_YEAR));
    end else begin
      yday_nxt = days6_r[elc_pkg::YDAY_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      e_r <= elapsed;
    end
    qs_r     <= prod100[62:37];
    secs_r   <= 27'(qs_r) + 27'(offset);
    mins4_r  <= mins_q[elc_pkg::MINS_W-1:0];
    secs4_r  <= secs_r;
    sec5_r   <= sec_rem[elc_pkg::SECOND_W-1:0];
    hours5_r <= hours_q[elc_pkg::HOURS_W-1:0];
    mins5_r  <= mins4_r;
    min6_r   <= min_rem[elc_pkg::MINUTE_W-1:0];
    days6_r  <= elc_pkg::div24(hours5_r);
    hours6_r <= hours5_r;
    sec6_r   <= sec5_r;
    hour7_r  <= hour_rem[elc_pkg::HOUR_W-1:0];
    yday7_r  <= yday_nxt;
    min7_r   <= min6_r;
    sec7_r   <= sec6_r;
  end

  assign fields.valid  = s7_v_r;
  assign fields.yday   = yday7_r;
  assign fields.hour   = hour7_r;
  assign fields.minute = min7_r;
  assign fields.second = sec7_r;

endmodule

/* hw/rtl/elc_month.sv */
`timescale 1ns / 1ps

module elc_month (
  input  logic                          clk,
  input  logic                          rst_n,
  input  elc_pkg::clock_fields_t        fields,
  output logic                          out_strobe,
  output logic [elc_pkg::MONTH_W-1:0]   out_month,
  output logic [elc_pkg::DAY_W-1:0]     out_day,
  output logic [elc_pkg::HOUR_W-1:0]    out_hour,
  output logic [elc_pkg::MINUTE_W-1:0]  out_minute,
  output logic [elc_pkg::SECOND_W-1:0]  out_second
);

  logic                          valid_r;
  logic [elc_pkg::MONTH_W-1:0]   month_r;
  logic [elc_pkg::DAY_W-1:0]     day_r;
  logic [elc_pkg::HOUR_W-1:0]    hour_r;
  logic [elc_pkg::MINUTE_W-1:0]  minute_r;
  logic [elc_pkg::SECOND_W-1:0]  second_r;
  logic [elc_pkg::MONTH_W-1:0]   month_nxt;
  logic [elc_pkg::YDAY_W-1:0]    day_nxt;

  always_comb begin
    month_nxt = 4'(elc_pkg::MONTHS - 1);
    for (int i = elc_pkg::MONTHS - 1; i >= 0; i--) begin
      if (fields.yday < elc_pkg::CUM_DAYS[i]) begin
        month_nxt = 4'(i);
      end
    end
    day_nxt = fields.yday - elc_pkg::days_before(month_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= fields.valid;
    end
  end

  always_ff @(posedge clk) begin
    month_r  <= month_nxt;
    day_r    <= day_nxt[elc_pkg::DAY_W-1:0];
    hour_r   <= fields.hour;
    minute_r <= fields.minute;
    second_r <= fields.second;
  end

  assign out_strobe = valid_r;
  assign out_month  = month_r;
  assign out_day    = day_r;
  assign out_hour   = hour_r;
  assign out_minute = minute_r;
  assign out_second = second_r;

endmodule

/* hw/rtl/elapsed_count_to_calendar_core.sv */
`timescale 1ns / 1ps

// Channel  Handshake            Payload
// request  start / busy         in_elapsed_centis
// result   out_strobe           out_month, out_day, out_hour, out_minute, out_second
// config   cfg_we               cfg_index, cfg_data
//
// A request is taken in every cycle in which start is high and busy is low.
// Its result appears on out_strobe after eight register stages; they hold the input
// capture, the divide by 100, the start offset add, the two divides by 60, the divide
// by 24, the year wrap, and the month lookup.
// busy is high during reset and in the first cycle after it; after that the pipeline
// takes one request per cycle.
// The receiver cannot stall, so the pipeline never holds.

module elapsed_count_to_calendar_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [elc_pkg::ELAPSED_W-1:0]     in_elapsed_centis,
  output logic                              out_strobe,
  output logic [elc_pkg::MONTH_W-1:0]       out_month,
  output logic [elc_pkg::DAY_W-1:0]         out_day,
  output logic [elc_pkg::HOUR_W-1:0]        out_hour,
  output logic [elc_pkg::MINUTE_W-1:0]      out_minute,
  output logic [elc_pkg::SECOND_W-1:0]      out_second,
  input  logic                              cfg_we,
  input  logic [elc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [elc_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic                          busy_r;
  logic                          accept;
  logic [elc_pkg::OFFSET_W-1:0]  offset;
  elc_pkg::clock_fields_t        fields;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy   = busy_r;
  assign accept = start && !busy_r;

  elc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .offset    (offset)
  );

  elc_split u_split (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (accept),
    .elapsed  (in_elapsed_centis),
    .offset   (offset),
    .fields   (fields)
  );

  elc_month u_month (
    .clk        (clk),
    .rst_n      (rst_n),
    .fields     (fields),
    .out_strobe (out_strobe),
    .out_month  (out_month),
    .out_day    (out_day),
    .out_hour   (out_hour),
    .out_minute (out_minute),
    .out_second (out_second)
  );

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, 8))
    else $error("result without a request eight cycles earlier");

  a_ranges: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_second < 6'd60 && out_minute < 6'd60 && out_hour < 5'd24
                    && out_month < 4'd12))
    else $error("result field out of range");

  a_day_in_month: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (6'(out_day) < elc_pkg::month_len(out_month)))
    else $error("day beyond the length of its month");

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps

module tb;
  import elc_pkg::*;

  typedef struct packed {
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [SECOND_W-1:0] second;
  } start_moment_t;

  typedef struct packed {
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [SECOND_W-1:0] second;
  } calendar_t;

  localparam logic [MONTH_W-1:0] LAST_MONTH = 4'd11;
  localparam int unsigned DAYS_THROUGH [12] = '{
    31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365
  };
  localparam longint unsigned CENTIS_PER_DAY = 64'd8640000;
  localparam int DRAIN_CYCLES = 12;
  localparam int STALL_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [ELAPSED_W-1:0] in_elapsed_centis = '0;
  logic out_strobe;
  logic [MONTH_W-1:0] out_month;
  logic [DAY_W-1:0] out_day;
  logic [HOUR_W-1:0] out_hour;
  logic [MINUTE_W-1:0] out_minute;
  logic [SECOND_W-1:0] out_second;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  start_moment_t moment = '{month: 4'd5, day: 5'd29, hour: 5'd23, minute: 6'd59, second: 6'd50};
  logic [ELAPSED_W-1:0] pending_counts [$];
  calendar_t calendar_due [$];
  int requests_taken = 0;
  int results_seen = 0;
  int mismatches = 0;
  int settings_used = 1;
  int idle_cycles = 0;
  int burst_left = 1;
  int gap_left = 0;

  elapsed_count_to_calendar_core i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_elapsed_centis(in_elapsed_centis),
    .out_strobe(out_strobe),
    .out_month(out_month),
    .out_day(out_day),
    .out_hour(out_hour),
    .out_minute(out_minute),
    .out_second(out_second),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic longint unsigned start_centis(input start_moment_t sm);
    logic [MONTH_W-1:0] m;
    longint unsigned d;
    m = (sm.month > LAST_MONTH) ? LAST_MONTH : sm.month;
    d = longint'(sm.day);
    if (m != '0) begin
      d += DAYS_THROUGH[m - 1];
    end
    return (d * 86400 + longint'(sm.hour) * 3600 + longint'(sm.minute) * 60
            + longint'(sm.second)) * 100;
  endfunction

  function automatic calendar_t calendar_of(input logic [ELAPSED_W-1:0] centis,
                                            input start_moment_t sm);
    calendar_t r;
    longint unsigned secs;
    int unsigned yday;
    bit found;
    secs = (longint'(centis) + start_centis(sm)) / 100;
    r.second = SECOND_W'(secs % 60);
    secs = secs / 60;
    r.minute = MINUTE_W'(secs % 60);
    secs = secs / 60;
    r.hour = HOUR_W'(secs % 24);
    secs = secs / 24;
    yday = int'(secs % 365);
    r.month = LAST_MONTH;
    found = 1'b0;
    for (int k = 0; k < 12; k++) begin
      if (!found && yday < DAYS_THROUGH[k]) begin
        r.month = MONTH_W'(k);
        found = 1'b1;
      end
    end
    r.day = (r.month != '0) ? DAY_W'(yday - DAYS_THROUGH[r.month - 1]) : DAY_W'(yday);
    return r;
  endfunction

  // Random counts, and counts near month and year boundaries of the running calendar.
  function automatic logic [ELAPSED_W-1:0] pick_count(input start_moment_t sm);
    longint target;
    int unsigned mode;
    int unsigned b;
    mode = $urandom_range(0, 9);
    if (mode < 5) begin
      return $urandom;
    end
    if (mode < 7) begin
      return $urandom_range(0, 2 * 8640000);
    end
    b = $urandom_range(0, 12);
    target = longint'($urandom_range(0, 1)) * 365 + ((b == 0) ? 0 : longint'(DAYS_THROUGH[b - 1]));
    target = target * longint'(CENTIS_PER_DAY) + longint'($urandom_range(0, 12000)) - 6000
             - longint'(start_centis(sm));
    if (target < 0 || target > 64'sh0FFFFFFFF) begin
      return $urandom;
    end
    return target[ELAPSED_W-1:0];
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        calendar_due.push_back(calendar_of(in_elapsed_centis, moment));
        requests_taken++;
      end
      if (start && busy) begin
      end else if (gap_left != 0) begin
        start <= 1'b0;
        gap_left--;
      end else if (pending_counts.size() == 0) begin
        start <= 1'b0;
      end else begin
        in_elapsed_centis <= pending_counts.pop_front();
        start <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                   : $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0
                   : (($urandom_range(0, 9) == 0) ? $urandom_range(10, 25)
                                                  : $urandom_range(1, 8));
        end else begin
          burst_left--;
        end
      end
    end
  end

  always @(posedge clk) begin
    calendar_t want;
    if ((start && !busy) || out_strobe) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("elapsed_count_to_calendar_core: mismatch");
      $finish;
    end else if (rst_n && out_strobe) begin
      results_seen++;
      if (calendar_due.size() == 0) begin
        $error("result with no request outstanding");
        mismatches++;
      end else begin
        want = calendar_due.pop_front();
        if (out_month !== want.month) begin
          $error("out_month: expected %0d, got %0d", want.month, out_month);
          mismatches++;
        end
        if (out_day !== want.day) begin
          $error("out_day: expected %0d, got %0d", want.day, out_day);
          mismatches++;
        end
        if (out_hour !== want.hour) begin
          $error("out_hour: expected %0d, got %0d", want.hour, out_hour);
          mismatches++;
        end
        if (out_minute !== want.minute) begin
          $error("out_minute: expected %0d, got %0d", want.minute, out_minute);
          mismatches++;
        end
        if (out_second !== want.second) begin
          $error("out_second: expected %0d, got %0d", want.second, out_second);
          mismatches++;
        end
      end
    end
  end

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_counts.size() != 0 || start || calendar_due.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_START_MONTH: moment.month = val[MONTH_W-1:0];
      REG_START_DAY: moment.day = val[DAY_W-1:0];
      REG_START_HOUR: moment.hour = val[HOUR_W-1:0];
      REG_START_MINUTE: moment.minute = val[MINUTE_W-1:0];
      REG_START_SECOND: moment.second = val[SECOND_W-1:0];
      default: begin
      end
    endcase
  endtask

  // A write to an unused index goes along with every setting and must change nothing.
  task automatic set_start(input logic [CFG_DATA_W-1:0] m, input logic [CFG_DATA_W-1:0] d,
                           input logic [CFG_DATA_W-1:0] h, input logic [CFG_DATA_W-1:0] mi,
                           input logic [CFG_DATA_W-1:0] s);
    write_reg(REG_START_MONTH, m);
    write_reg(CFG_INDEX_W'(REG_START_SECOND + 1 + $urandom_range(0, 2)), CFG_DATA_W'($urandom));
    write_reg(REG_START_DAY, d);
    write_reg(REG_START_HOUR, h);
    write_reg(REG_START_MINUTE, mi);
    write_reg(REG_START_SECOND, s);
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic queue_random(input int n);
    for (int k = 0; k < n; k++) begin
      pending_counts.push_back(pick_count(moment));
    end
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_field(input int unsigned hi);
    if ($urandom_range(0, 3) == 0) begin
      return CFG_DATA_W'($urandom_range(0, 63));
    end
    return CFG_DATA_W'($urandom_range(0, hi));
  endfunction

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    pending_counts.push_back(32'd0);
    pending_counts.push_back(32'hFFFFFFFF);
    pending_counts.push_back(32'hFFFFFFFE);
    pending_counts.push_back(32'd99);
    pending_counts.push_back(32'd100);
    pending_counts.push_back(32'd1000);
    pending_counts.push_back(32'h80000000);
    pending_counts.push_back(32'h7FFFFFFF);
    pending_counts.push_back(32'h55555555);
    pending_counts.push_back(32'hAAAAAAAA);
    queue_random(250);
    wait_drained();

    set_start('0, '0, '0, '0, '0);
    for (int k = 0; k < 12; k++) begin
      pending_counts.push_back(32'(longint'(DAYS_THROUGH[k]) * CENTIS_PER_DAY - 1));
    end
    pending_counts.push_back(32'(365 * CENTIS_PER_DAY));
    queue_random(240);
    wait_drained();

    set_start(6'd11, 6'd30, 6'd23, 6'd59, 6'd59);
    queue_random(250);
    wait_drained();

    set_start(6'd63, 6'd63, 6'd63, 6'd63, 6'd63);
    queue_random(250);
    wait_drained();

    set_start(6'd12, 6'd31, 6'd24, 6'd60, 6'd60);
    queue_random(100);
    wait_drained();

    repeat (5) begin
      set_start(pick_field(11), pick_field(30), pick_field(23), pick_field(59),
                pick_field(59));
      queue_random(170);
      wait_drained();
    end

    $display("Ran %0d requests against %0d results across %0d start-moment settings,",
             requests_taken, results_seen, settings_used);
    $display("including out-of-range start fields and counts at month and year edges.");
    if (mismatches == 0 && calendar_due.size() == 0) begin
      $display("elapsed_count_to_calendar_core: match");
    end else begin
      $display("elapsed_count_to_calendar_core: mismatch");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/elc_pkg.sv
hw/rtl/elc_cfg.sv
hw/rtl/elc_split.sv
hw/rtl/elc_month.sv
hw/rtl/elapsed_count_to_calendar_core.sv
tb/sv/tb.sv
